@@ sv/rthsv_pkg.sv @@
package rthsv_pkg;

    localparam int CH_W   = 8;
    localparam int NUM_W  = 20;
    localparam int QUO_W  = 12;
    localparam int HUE_W  = 15;
    localparam int DIV_LAT = QUO_W + 1;

    localparam int HUE_SIXTH = 3840;
    localparam int HUE_TURN  = 23040;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [NUM_W-1:0] num_t;
    typedef logic [QUO_W-1:0] quo_t;
    typedef logic [HUE_W-1:0] hue_t;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    // what travels beside the dividers
    typedef struct packed {
        chan_t   value;
        sector_t sector;
        logic    neg;
    } side_t;

    function automatic hue_t sector_offset(sector_t sec);
        hue_t off;
        unique case (sec)
            SEC_RED:   off = '0;
            SEC_GREEN: off = hue_t'(2 * HUE_SIXTH);
            SEC_BLUE:  off = hue_t'(4 * HUE_SIXTH);
            default:   off = '0;
        endcase
        return off;
    endfunction

endpackage

@@ sv/rthsv_div.sv @@
module rthsv_div (
    input  logic             clk,
    input  logic             en,
    input  rthsv_pkg::num_t  num,
    input  rthsv_pkg::chan_t den,
    output rthsv_pkg::quo_t  quo,
    output rthsv_pkg::num_t  rem
);
    import rthsv_pkg::*;

    // restoring division, one quotient bit per stage, msb first
    num_t  rem_reg [0:QUO_W];
    quo_t  quo_reg [0:QUO_W];
    chan_t den_reg [0:QUO_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            quo_reg[0] <= '0;
            den_reg[0] <= den;
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        localparam int BIT = QUO_W - 1 - k;
        num_t shifted;
        num_t diff;
        logic fits;

        assign shifted = num_t'(den_reg[k]) << BIT;
        assign fits    = rem_reg[k] >= shifted;
        assign diff    = rem_reg[k] - shifted;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= fits ? diff : rem_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (quo_t'(fits) << BIT);
            end
        end

        if (k < QUO_W - 1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign quo = quo_reg[QUO_W];
    assign rem = rem_reg[QUO_W];

endmodule

@@ sv/rgb_to_hsv_converter.sv @@
// throughput: one pixel per cycle unless the output stalls; the two 12-stage restoring dividers
// (hue and saturation) are fully pipelined, one quotient bit per stage
// a stall on the output freezes the whole pipeline, no item is lost
// reset clears the valid bits only; the data path holds no reset state
module rgb_to_hsv_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // hue[14:0], saturation[22:15],
                                       // brightness_value[30:23], zero[31]
);
    import rthsv_pkg::*;

    logic adv;
    logic v_reg [0:DIV_LAT];
    logic out_valid_reg;

    chan_t red, green, blue;
    chan_t mx, mn;
    sector_t sec;
    logic signed [CH_W:0] diff;

    chan_t               mx_reg, mn_reg;
    sector_t             sec_reg;
    logic signed [CH_W:0] diff_reg;

    chan_t delta, absd, den_h, den_s;
    num_t  num_h, num_s;
    logic  neg;

    side_t side_reg [0:DIV_LAT-1];
    quo_t  quo_h, quo_s;
    num_t  rem_h, rem_s;

    side_t                 side_out;
    logic [QUO_W:0]        qa;
    logic signed [HUE_W:0] off_s, hue_s, hue_w;
    hue_t                  hue_next;
    hue_t                  hue_reg;
    chan_t                 sat_reg, val_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    assign red   = s_axis_tdata[7:0];
    assign green = s_axis_tdata[15:8];
    assign blue  = s_axis_tdata[23:16];

    // max, min and sector; ties go to red, then green
    always_comb
    begin
        mx = red;
        mn = red;
        sec = SEC_RED;
        if (green > mx)
        begin
            mx = green;
            sec = SEC_GREEN;
        end
        if (blue > mx)
        begin
            mx = blue;
            sec = SEC_BLUE;
        end
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        case (sec)
            SEC_RED:   diff = $signed({1'b0, green}) - $signed({1'b0, blue});
            SEC_GREEN: diff = $signed({1'b0, blue}) - $signed({1'b0, red});
            default:   diff = $signed({1'b0, red}) - $signed({1'b0, green});
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg   <= mx;
            mn_reg   <= mn;
            sec_reg  <= sec;
            diff_reg <= diff;
        end
    end

    // numerators and divisors for the dividers; a zero divisor only shows with a zero numerator and is forced to one
    always_comb
    begin
        delta = mx_reg - mn_reg;
        neg   = diff_reg < 0;
        absd  = neg ? chan_t'(-diff_reg) : chan_t'(diff_reg);
        num_h = num_t'(absd) * num_t'(HUE_SIXTH);
        num_s = num_t'(delta) * num_t'(8'd255);
        den_h = (delta == '0) ? chan_t'(1) : delta;
        den_s = (mx_reg == '0) ? chan_t'(1) : mx_reg;
    end

    rthsv_div u_div_hue (
        .clk (clk),
        .en  (adv),
        .num (num_h),
        .den (den_h),
        .quo (quo_h),
        .rem (rem_h)
    );

    rthsv_div u_div_sat (
        .clk (clk),
        .en  (adv),
        .num (num_s),
        .den (den_s),
        .quo (quo_s),
        .rem (rem_s)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= '{value: mx_reg, sector: sec_reg, neg: neg};
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign side_out = side_reg[DIV_LAT-1];

    // floor for negative differences rounds the magnitude up
    always_comb
    begin
        qa    = {1'b0, quo_h} + (QUO_W+1)'(side_out.neg && (rem_h != '0));
        off_s = $signed({1'b0, sector_offset(side_out.sector)});
        hue_s = side_out.neg ? off_s - $signed((HUE_W+1)'(qa))
                             : off_s + $signed((HUE_W+1)'(qa));
        hue_w = (hue_s < 0) ? hue_s + (HUE_W+1)'(HUE_TURN) : hue_s;
        hue_next = hue_w[HUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue_reg <= hue_next;
            sat_reg <= quo_s[CH_W-1:0];
            val_reg <= side_out.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_LAT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= s_axis_tvalid;
            for (int i = 1; i <= DIV_LAT; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            out_valid_reg <= v_reg[DIV_LAT];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, val_reg, sat_reg, hue_reg};

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14:0] < hue_t'(HUE_TURN)))
        else $error("hue out of range");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[30:23] == '0)
        |-> (m_axis_tdata[22:0] == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[22:15] == '0) |-> (m_axis_tdata[14:0] == '0))
        else $error("zero saturation with nonzero hue");

endmodule

@@ tb/sv/tb.sv @@
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rthsv_pkg::*;

    typedef struct packed {
        hue_t  hue;
        chan_t sat;
        chan_t val;
    } hsv_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // hue[14:0], saturation[22:15], brightness_value[30:23]

    hsv_t pending_hsv[$];
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_request;
    int   errors;
    int   pixels_sent;
    int   hsv_checked;
    int   grey_pixels;
    int   wrapped_hues;
    int   sector_hits[3];

    rgb_to_hsv_converter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // fixed-point hsv of one pixel, hue in 1/64 degree
    function automatic hsv_t predict_hsv(chan_t r, chan_t g, chan_t b);
        int      rr, gg, bb, mx, mn, delta, num, h, off;
        sector_t sec;
        hsv_t    res;
        rr = r;
        gg = g;
        bb = b;
        mx = rr;
        mn = rr;
        if (gg > mx) mx = gg;
        if (bb > mx) mx = bb;
        if (gg < mn) mn = gg;
        if (bb < mn) mn = bb;
        delta = mx - mn;
        h = 0;
        if (delta != 0)
        begin
            // ties go to the earlier channel
            if (mx == rr)
            begin
                sec = SEC_RED;
                num = gg - bb;
                off = 0;
            end
            else if (mx == gg)
            begin
                sec = SEC_GREEN;
                num = bb - rr;
                off = 2 * HUE_SIXTH;
            end
            else
            begin
                sec = SEC_BLUE;
                num = rr - gg;
                off = 4 * HUE_SIXTH;
            end
            num = num * HUE_SIXTH;
            // round toward minus infinity
            if (num >= 0)
                h = num / delta;
            else
                h = -((-num + delta - 1) / delta);
            h = h + off;
            sector_hits[sec]++;
            if (h < 0)
            begin
                h = h + HUE_TURN;
                wrapped_hues++;
            end
        end
        else
        begin
            grey_pixels++;
        end
        res.hue = hue_t'(h);
        res.sat = (mx == 0) ? chan_t'(0) : chan_t'((delta * 255) / mx);
        res.val = chan_t'(mx);
        return res;
    endfunction

    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_hsv.push_back(predict_hsv(r, g, b));
        pixels_sent++;
    endtask

    task automatic test_directed_pixels();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_pixel(8'd0,   8'd0,   8'd0);    // black
        send_pixel(8'd255, 8'd255, 8'd255);  // white
        send_pixel(8'd128, 8'd128, 8'd128);  // grey
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);    // red and green tie
        send_pixel(8'd0,   8'd255, 8'd255);  // green and blue tie
        send_pixel(8'd255, 8'd0,   8'd255);  // red and blue tie, wraps
        send_pixel(8'd255, 8'd0,   8'd1);    // red sector, just below full turn
        send_pixel(8'd255, 8'd0,   8'd254);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd200, 8'd199);
        send_pixel(8'd3,   8'd7,   8'd250);
        send_pixel(8'd100, 8'd30,  8'd200);
        send_pixel(8'd170, 8'd85,  8'd0);
        send_pixel(8'd254, 8'd1,   8'd255);
    endtask

    task automatic test_random_pixels(input int count, input int s_pct, input int r_pct);
        chan_t r, g, b;
        chan_t edge_val;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count)
        begin
            r = chan_t'($urandom);
            g = chan_t'($urandom);
            b = chan_t'($urandom);
            edge_val = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
            case ($urandom_range(9))
                0: begin
                    g = r;
                    b = r;
                end
                1: g = r;
                2: b = g;
                3: r = b;
                4: r = edge_val;
                5: g = edge_val;
                6: b = edge_val;
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    // output held off long enough that the pipeline fills and stops taking input
    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 200;
        repeat (80)
            send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            hsv_t exp_hsv;
            hsv_t got_hsv;
            got_hsv.hue = m_axis_tdata[14:0];
            got_hsv.sat = m_axis_tdata[22:15];
            got_hsv.val = m_axis_tdata[30:23];
            if (pending_hsv.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual 0x%08h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_hsv = pending_hsv.pop_front();
                hsv_checked++;
                if (got_hsv.hue !== exp_hsv.hue)
                begin
                    $display("%0t: hue mismatch, expected %0d, actual %0d",
                             $time, exp_hsv.hue, got_hsv.hue);
                    errors++;
                end
                if (got_hsv.sat !== exp_hsv.sat)
                begin
                    $display("%0t: saturation mismatch, expected %0d, actual %0d",
                             $time, exp_hsv.sat, got_hsv.sat);
                    errors++;
                end
                if (got_hsv.val !== exp_hsv.val)
                begin
                    $display("%0t: brightness_value mismatch, expected %0d, actual %0d",
                             $time, exp_hsv.val, got_hsv.val);
                    errors++;
                end
                if (m_axis_tdata[31] !== 1'b0)
                begin
                    $display("%0t: pad bit mismatch, expected 0, actual %b",
                             $time, m_axis_tdata[31]);
                    errors++;
                end
            end
        end
    end

    // output ready, with long hold-offs counted here
    always @(posedge clk)
    begin
        int hold_left;
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #2ms;
        $display("timeout with %0d results outstanding", pending_hsv.size());
        $display("rgb_to_hsv_converter regression: fail");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 0;
        errors        = 0;
        pixels_sent   = 0;
        hsv_checked   = 0;
        grey_pixels   = 0;
        wrapped_hues  = 0;
        sector_hits   = '{0, 0, 0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_pixels();
        test_random_pixels(350, 27, 65);
        test_random_pixels(350, 65, 27);
        test_random_pixels(350, 0, 0);
        test_backpressure_fill();
        test_random_pixels(40, 27, 65);

        s_axis_tvalid <= 1'b0;
        recv_idle_pct = 0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("pixels %0d, results checked %0d, grey %0d, wrapped hues %0d",
                 pixels_sent, hsv_checked, grey_pixels, wrapped_hues);
        $display("sectors red %0d green %0d blue %0d, idle mixes and output hold-off run",
                 sector_hits[SEC_RED], sector_hits[SEC_GREEN], sector_hits[SEC_BLUE]);
        if (errors == 0 && pending_hsv.size() == 0)
            $display("rgb_to_hsv_converter regression: pass");
        else
            $display("rgb_to_hsv_converter regression: fail");
        $finish;
    end

endmodule
